// ----- rtl/ads_pkg.sv -----
// ----------------------------------------------------------------------------
// ads_pkg
// Shared constants and controller/datapath interface types for the aliquot
// divisor sum block.
// ----------------------------------------------------------------------------
package ads_pkg;

   localparam int NumberWidthDefault = 31;
   localparam int SumWidth           = 35;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic next;
      logic out_load;
   } ads_cmd_type;

   typedef struct packed {
      logic n_small;
      logic sq_gt_n;
      logic div_last;
   } ads_status_type;

endpackage

// ----- rtl/ads_datapath.sv -----
// ----------------------------------------------------------------------------
// ads_datapath
// Trial divisor and running square, bit-serial restoring divider, sum
// accumulator and result register.
// ----------------------------------------------------------------------------
module ads_datapath
   import ads_pkg::*;
#(
   parameter int NUMBER_WIDTH = NumberWidthDefault
) (
   input  logic                    clock,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   input  ads_cmd_type             cmd,
   output ads_status_type          status,
   output logic [SumWidth-1:0]     rsp_divisor_sum
);

   localparam int NW   = NUMBER_WIDTH;
   localparam int CntW = $clog2(NW);
   localparam int AccW = ((NW > SumWidth) ? NW : SumWidth) + 1;

   logic [NW-1:0]       n_ff, n_in;
   logic [NW-1:0]       d_ff, d_in;
   logic [NW:0]         sq_ff, sq_in;
   logic [NW-1:0]       rem_ff, rem_in;
   logic [NW-1:0]       quo_ff, quo_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [SumWidth-1:0] total_ff, total_in;
   logic [SumWidth-1:0] out_ff, out_in;

   logic [NW:0]         shifted;
   logic [NW:0]         diff;
   logic                ge;
   logic [AccW-1:0]     addend;
   logic [AccW-1:0]     acc;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign diff    = shifted - {1'b0, d_ff};
   assign ge      = shifted >= {1'b0, d_ff};

   always_comb begin
      if (quo_ff == d_ff) begin
         addend = {{(AccW-NW){1'b0}}, d_ff};
      end else begin
         addend = {{(AccW-NW){1'b0}}, d_ff} + {{(AccW-NW){1'b0}}, quo_ff};
      end
      acc = {{(AccW-SumWidth){1'b0}}, total_ff} + addend;
   end

   always_comb begin
      n_in     = n_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         n_in     = req_number;
         d_in     = NW'(2);
         sq_in    = (NW+1)'(4);
         total_in = (req_number > NW'(1)) ? SumWidth'(1) : '0;
      end
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = n_ff;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? diff[NW-1:0] : shifted[NW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CntW'(1);
      end
      if (cmd.next) begin
         if (rem_ff == '0) begin
            total_in = acc[SumWidth-1:0];
         end
         d_in  = d_ff + NW'(1);
         sq_in = sq_ff + {d_ff, 1'b1};
      end
      if (cmd.out_load) begin
         out_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      total_ff <= total_in;
      out_ff   <= out_in;
   end

   assign status.n_small  = n_ff <= NW'(1);
   assign status.sq_gt_n  = sq_ff > {1'b0, n_ff};
   assign status.div_last = cnt_ff == CntW'(NW-1);

   assign rsp_divisor_sum = out_ff;

endmodule

// ----- rtl/ads_controller.sv -----
// ----------------------------------------------------------------------------
// ads_controller
// Sequencer for the trial-division loop and the input and result handshakes.
// ----------------------------------------------------------------------------
module ads_controller
   import ads_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  ads_status_type status,
   output ads_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DIVIDE,
      ACCUM,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.n_small || status.sq_gt_n) begin
               state_in = FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = DIVIDE;
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ACCUM;
            end
         end
         ACCUM: begin
            cmd.next = 1'b1;
            state_in = CHECK;
         end
         FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/aliquot_divisor_sum.sv -----
// Sequence: per trial divisor d (2 <= d, d*d <= number) the states CHECK, DIVIDE and ACCUM,
//   DIVIDE using the one-bit-per-cycle restoring divider; FINISH loads the result when free.
// Acceptance: one item at a time, a new number is taken only in IDLE; the next item is
//   taken while a result waits on rsp_stall.
// Reset: synchronous, clears the sequencer and the result valid; no clearing pass.
// ----------------------------------------------------------------------------
// aliquot_divisor_sum
// Sum of the proper divisors of a positive integer by trial division.
// ----------------------------------------------------------------------------
module aliquot_divisor_sum
   import ads_pkg::*;
#(
   parameter int NUMBER_WIDTH = NumberWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [SumWidth-1:0]     rsp_divisor_sum
);

   ads_cmd_type    cmd;
   ads_status_type status;

   ads_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ads_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dp (
      .clock           (clock),
      .req_number      (req_number),
      .cmd             (cmd),
      .status          (status),
      .rsp_divisor_sum (rsp_divisor_sum)
   );

endmodule

// ----- rtl/ads_checker.sv -----
// ----------------------------------------------------------------------------
// ads_checker
// Port-level checks for the aliquot divisor sum block, bound to the top level.
// ----------------------------------------------------------------------------
module ads_checker
   import ads_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SumWidth-1:0]     rsp_divisor_sum
);

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_divisor_sum))
      else $error("stalled result payload changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("second beat taken while busy");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid |=> !rsp_valid)
      else $error("result appeared the cycle after the request");

endmodule

bind aliquot_divisor_sum ads_checker u_ads_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_divisor_sum (rsp_divisor_sum)
);
